### rtl/core/srec_pkg.sv
// ----------------------------------------------------------------------------
// srec_pkg: shared types and helpers for the S-record line parser
// Result kinds, character constants and the hex and record-type decoders.
// ----------------------------------------------------------------------------
package srec_pkg;

   typedef enum logic [1:0] {
      EV_WRITE     = 2'd0,
      EV_FLOOR_ERR = 2'd1,
      EV_END       = 2'd2
   } event_kind_type;

   localparam logic [7:0]  CHAR_CR      = 8'h0D;
   localparam logic [31:0] FLOOR_RESET  = 32'h0000_8000;
   localparam logic [3:0]  TYPE_NONE    = 4'd0;
   localparam logic [3:0]  TYPE_DATA16  = 4'd1;
   localparam logic [3:0]  TYPE_DATA24  = 4'd2;
   localparam logic [3:0]  TYPE_DATA32  = 4'd3;
   localparam logic [3:0]  TYPE_TERM32  = 4'd7;
   localparam logic [3:0]  TYPE_TERM24  = 4'd8;
   localparam logic [3:0]  TYPE_END     = 4'd9;

   // Non-hex characters decode as zero.
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

   function automatic logic [3:0] addr_digits(input logic [3:0] rtype);
      logic [3:0] n;
      case (rtype)
         TYPE_DATA16, TYPE_END:    n = 4'd4;
         TYPE_DATA24, TYPE_TERM24: n = 4'd6;
         TYPE_DATA32, TYPE_TERM32: n = 4'd8;
         default:                  n = 4'd0;
      endcase
      return n;
   endfunction

   // Data digits on the line: twice the count less address bytes and checksum.
   function automatic logic [8:0] data_digits(input logic [7:0] count,
                                              input logic [3:0] adig);
      logic [7:0] overhead;
      logic [7:0] diff;
      overhead = {5'd0, adig[3:1]} + 8'd1;
      diff     = count - overhead;
      if (count <= overhead) begin
         return 9'd0;
      end
      return {diff, 1'b0};
   endfunction

endpackage

### rtl/core/srec_line_to_flash_words.sv
// ----------------------------------------------------------------------------
// srec_line_to_flash_words: S-record text to 32-bit flash word writes
// Parses S-record characters and emits flash writes, floor errors and end
// events.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one text character per word (req_in_byte). A carriage
//   return ends a line. req_stall rises only while a result is held in the
//   output register and the receiver stalls it.
//   rsp_ channel: one result word per completed data word (event kind 0),
//   per base-below-floor abort (kind 1) or per S9 line end (kind 2).
//   csr_ channel: writes write_floor; always ready. Write only when idle.
// Output: a result appears in the output register in the cycle after the
//   character that causes it is accepted.
// Throughput: one character per cycle while req_stall is low; the parse registers
//   update in a single pass and the output register takes a result every cycle unless its word is stalled.
// Reset: clears the parse state and output valid, sets write_floor to 0x8000.
// Receiver stall: the output register holds its word; input is stalled only
//   while that word is still held.
// ----------------------------------------------------------------------------
module srec_line_to_flash_words
   import srec_pkg::*;
#(
   parameter int LINE_MAX = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [31:0] rsp_write_address,
   output logic [31:0] rsp_write_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_write_floor
);

   localparam int PW = $clog2(LINE_MAX);
   localparam logic [PW-1:0] POS_LIMIT = PW'(LINE_MAX - 1);

   logic [31:0]    floor_ff;
   logic [PW-1:0]  pos_ff, pos_in;
   logic [3:0]     type_ff, type_in;
   logic [7:0]     count_ff, count_in;
   logic [31:0]    base_ff, base_in;
   logic [31:0]    acc_ff, acc_in;
   logic [7:0]     offset_ff, offset_in;
   logic [8:0]     left_ff, left_in;
   logic [2:0]     nib_cnt_ff, nib_cnt_in;
   logic           aborted_ff, aborted_in;

   logic           rsp_valid_ff;
   event_kind_type kind_ff, kind_in;
   logic [31:0]    addr_ff, addr_in;
   logic [31:0]    data_ff, data_in;
   logic           res_load;

   logic           req_acc;
   logic [3:0]     nib;
   logic [3:0]     adig;
   logic [PW-1:0]  adig_ext;
   logic [31:0]    acc_shift;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign nib       = hex_nibble(req_in_byte);
   assign adig      = addr_digits(type_ff);
   assign adig_ext  = PW'(adig);
   assign acc_shift = {acc_ff[27:0], nib};

   always_comb begin
      pos_in     = pos_ff;
      type_in    = type_ff;
      count_in   = count_ff;
      base_in    = base_ff;
      acc_in     = acc_ff;
      offset_in  = offset_ff;
      left_in    = left_ff;
      nib_cnt_in = nib_cnt_ff;
      aborted_in = aborted_ff;
      res_load   = 1'b0;
      kind_in    = EV_WRITE;
      addr_in    = 32'd0;
      data_in    = 32'd0;
      if (req_acc) begin
         if (req_in_byte == CHAR_CR) begin
            if (type_ff == TYPE_END && !aborted_ff) begin
               res_load = 1'b1;
               kind_in  = EV_END;
            end
            pos_in     = '0;
            type_in    = TYPE_NONE;
            count_in   = 8'd0;
            base_in    = 32'd0;
            acc_in     = 32'd0;
            offset_in  = 8'd0;
            left_in    = 9'd0;
            nib_cnt_in = 3'd0;
            aborted_in = 1'b0;
         end else if (pos_ff < POS_LIMIT) begin
            pos_in = pos_ff + PW'(1);
            if (pos_ff == PW'(1)) begin
               type_in = nib;
            end else if (pos_ff > PW'(1) && type_ff != TYPE_NONE) begin
               if (pos_ff < PW'(4)) begin
                  count_in = {count_ff[3:0], nib};
                  if (pos_ff == PW'(3) && adig == 4'd0) begin
                     left_in = data_digits(count_in, adig);
                  end
               end else if (pos_ff < PW'(4) + adig_ext) begin
                  base_in = {base_ff[27:0], nib};
                  if (pos_ff == PW'(3) + adig_ext) begin
                     left_in = data_digits(count_ff, adig);
                  end
               end else if (left_ff != 9'd0 && !aborted_ff) begin
                  left_in    = left_ff - 9'd1;
                  nib_cnt_in = nib_cnt_ff + 3'd1;
                  acc_in     = acc_shift;
                  // emit on a full word or on the last digit of the line
                  if (nib_cnt_ff == 3'd7 || left_in == 9'd0) begin
                     res_load  = 1'b1;
                     addr_in   = base_ff + {24'd0, offset_ff};
                     offset_in = offset_ff + 8'd4;
                     acc_in    = 32'd0;
                     if (base_ff < floor_ff) begin
                        kind_in    = EV_FLOOR_ERR;
                        aborted_in = 1'b1;
                     end else begin
                        kind_in = EV_WRITE;
                        // zero-pad a short word in its low digits
                        data_in = acc_shift << {~nib_cnt_ff, 2'b00};
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff     <= FLOOR_RESET;
         pos_ff       <= '0;
         type_ff      <= TYPE_NONE;
         count_ff     <= 8'd0;
         base_ff      <= 32'd0;
         acc_ff       <= 32'd0;
         offset_ff    <= 8'd0;
         left_ff      <= 9'd0;
         nib_cnt_ff   <= 3'd0;
         aborted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            floor_ff <= csr_write_floor;
         end
         pos_ff     <= pos_in;
         type_ff    <= type_in;
         count_ff   <= count_in;
         base_ff    <= base_in;
         acc_ff     <= acc_in;
         offset_ff  <= offset_in;
         left_ff    <= left_in;
         nib_cnt_ff <= nib_cnt_in;
         aborted_ff <= aborted_in;
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         kind_ff <= kind_in;
         addr_ff <= addr_in;
         data_ff <= data_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_kind    = kind_ff;
   assign rsp_write_address = addr_ff;
   assign rsp_write_data    = data_ff;

   a_cr_clears_line: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_in_byte == CHAR_CR) |=> (pos_ff == '0 && !aborted_ff))
      else $error("line state not cleared after carriage return");

   a_no_result_after_abort: assert property (@(posedge clock) disable iff (reset)
      res_load |-> !aborted_ff)
      else $error("result produced on an aborted line");

   a_floor_err_aborts: assert property (@(posedge clock) disable iff (reset)
      (res_load && kind_in == EV_FLOOR_ERR) |=> aborted_ff)
      else $error("floor error did not abort the line");

   a_data_needs_type: assert property (@(posedge clock) disable iff (reset)
      (left_ff != 9'd0) |-> (type_ff != TYPE_NONE))
      else $error("data digits pending on a type 0 line");

   a_result_not_lost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !res_load)
      else $error("result loaded over a stalled word");

endmodule
